@@ hdl/fqs_pkg.sv @@
// ----------------------------------------------------------------------------
// fqs_pkg
// Shared codes and the command and status bundles between controller and
// datapath of the searchable queue.
// ----------------------------------------------------------------------------
package fqs_pkg;

  localparam logic [2:0] CMD_ENQ     = 3'd0;
  localparam logic [2:0] CMD_DEQ     = 3'd1;
  localparam logic [2:0] CMD_READ    = 3'd2;
  localparam logic [2:0] CMD_SEARCH  = 3'd3;
  localparam logic [2:0] CMD_REVERSE = 3'd4;
  localparam logic [2:0] CMD_CLEAR   = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_UNDER    = 2'd1;
  localparam logic [1:0] ST_OVER     = 2'd2;
  localparam logic [1:0] ST_INDEX    = 2'd3;

  typedef struct packed {
    logic load;
    logic exec;
    logic capture;
    logic search;
    logic rd_front;
    logic rd_back;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic needs_read;
    logic is_search;
    logic search_done;
  } dp_stat_t;

endpackage

@@ hdl/fqs_ctrl.sv @@
// ----------------------------------------------------------------------------
// fqs_ctrl
// Sequencer of the searchable queue: steps one request through execute,
// data capture or search, front and back reads, and the result strobe.
// ----------------------------------------------------------------------------
module fqs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  fqs_pkg::dp_stat_t stat,
  output fqs_pkg::dp_cmd_t  ctl,
  output logic             busy,
  output logic             done
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_CAP   = 3'd2;
  localparam logic [2:0] S_SRCH  = 3'd3;
  localparam logic [2:0] S_FRONT = 3'd4;
  localparam logic [2:0] S_BACK  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec = 1'b1;
        priority if (stat.needs_read) state_next = S_CAP;
        else if (stat.is_search)      state_next = S_SRCH;
        else                          state_next = S_FRONT;
      end
      S_CAP: begin
        ctl.capture = 1'b1;
        state_next  = S_FRONT;
      end
      S_SRCH: begin
        ctl.search = 1'b1;
        if (stat.search_done) state_next = S_FRONT;
      end
      S_FRONT: begin
        ctl.rd_front = 1'b1;
        state_next   = S_BACK;
      end
      S_BACK: begin
        ctl.rd_back = 1'b1;
        state_next  = S_FIN;
      end
      S_FIN: begin
        ctl.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_FIN);
    end
  end

  assign busy = (state != S_IDLE);

  a_done_after_fin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_FIN)
    else $error("result strobe without finish step");

  a_start_enters_exec: assert property (@(posedge clk) disable iff (rst)
    (start && state == S_IDLE) |=> state == S_EXEC)
    else $error("accepted request did not enter execute");

endmodule

@@ hdl/fqs_dp.sv @@
// ----------------------------------------------------------------------------
// fqs_dp
// Datapath of the searchable queue: ring store with one write and one
// registered read port, front pointer, count, direction flag and result
// registers.
// ----------------------------------------------------------------------------
module fqs_dp #(
  parameter int DEPTH         = 16,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  fqs_pkg::dp_cmd_t  ctl,
  output fqs_pkg::dp_stat_t stat,
  input  logic [2:0]        command,
  input  logic [31:0]       value,
  input  logic [4:0]        index,
  output logic [1:0]        status,
  output logic [31:0]       data,
  output logic [4:0]        found_position,
  output logic [4:0]        occupancy,
  output logic              is_empty,
  output logic [31:0]       front_value,
  output logic [31:0]       back_value
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (CW > 5) ? CW : 5;
  localparam int EW = ELEMENT_WIDTH;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [PW:0]   DEPTH_W = (PW + 1)'(DEPTH);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rd_data;
  logic [PW-1:0] raddr;
  logic [PW-1:0] waddr;
  logic          we;

  logic [PW-1:0] fp;
  logic [CW-1:0] cnt;
  logic          rev;

  logic [2:0]    cmd_q;
  logic [EW-1:0] val_q;
  logic [4:0]    idx_q;

  logic [CW-1:0] pos;
  logic [CW-1:0] chk_pos;
  logic          chk_valid;

  logic [1:0]    status_q;
  logic [EW-1:0] data_q;
  logic [CW-1:0] found_q;
  logic [EW-1:0] fv;
  logic [EW-1:0] bv;

  logic          full;
  logic          idx_ok;
  logic          match;
  logic [CW-1:0] exec_pos;
  logic [PW-1:0] fp_dec;
  logic [IW-1:0] idx_x;
  logic [IW-1:0] cnt_x;

  function automatic logic [PW-1:0] slot_of(input logic [CW-1:0] p);
    logic [CW-1:0] off;
    logic [PW:0]   sum;
    off = rev ? (cnt - CW'(1) - p) : p;
    sum = {1'b0, fp} + {1'b0, off[PW-1:0]};
    if (sum >= DEPTH_W) sum = sum - DEPTH_W;
    return sum[PW-1:0];
  endfunction

  assign full   = (cnt == DEPTH_C);
  assign idx_x  = IW'(idx_q);
  assign cnt_x  = IW'(cnt);
  assign idx_ok = (idx_q != 5'd0) && (idx_x <= cnt_x);
  assign match  = chk_valid && (rd_data == val_q);
  assign fp_dec = (fp == '0) ? LAST_SLOT : fp - PW'(1);
  assign exec_pos = (cmd_q == fqs_pkg::CMD_DEQ) ? '0 : CW'(idx_q - 5'd1);

  assign stat.needs_read  = ((cmd_q == fqs_pkg::CMD_DEQ) && (cnt != '0)) ||
                            ((cmd_q == fqs_pkg::CMD_READ) && idx_ok);
  assign stat.is_search   = (cmd_q == fqs_pkg::CMD_SEARCH);
  assign stat.search_done = match || (pos >= cnt);

  // read address
  always_comb begin
    priority if (ctl.exec) raddr = slot_of(exec_pos);
    else if (ctl.search)   raddr = slot_of(pos);
    else if (ctl.rd_back)  raddr = slot_of(cnt - CW'(1));
    else                   raddr = slot_of('0);
  end

  assign we = ctl.exec && (cmd_q == fqs_pkg::CMD_ENQ) && !full;

  // write address
  always_comb begin
    waddr = rev ? fp_dec : slot_of(cnt);
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= val_q;
    rd_data <= mem[raddr];
  end

  // queue state
  always_ff @(posedge clk) begin
    if (rst) begin
      fp  <= '0;
      cnt <= '0;
      rev <= 1'b0;
    end else if (ctl.exec) begin
      unique case (cmd_q)
        fqs_pkg::CMD_ENQ: begin
          if (!full) begin
            if (rev) fp <= fp_dec;
            cnt <= cnt + CW'(1);
          end
        end
        fqs_pkg::CMD_REVERSE: rev <= ~rev;
        fqs_pkg::CMD_CLEAR: begin
          fp  <= '0;
          cnt <= '0;
          rev <= 1'b0;
        end
        default: ;
      endcase
    end else if (ctl.capture && (cmd_q == fqs_pkg::CMD_DEQ)) begin
      if (!rev) fp <= (fp == LAST_SLOT) ? '0 : fp + PW'(1);
      cnt <= cnt - CW'(1);
    end
  end

  // search walk
  always_ff @(posedge clk) begin
    if (rst) begin
      chk_valid <= 1'b0;
    end else if (ctl.load) begin
      chk_valid <= 1'b0;
      pos       <= '0;
    end else if (ctl.search && !match && (pos < cnt)) begin
      chk_valid <= 1'b1;
      chk_pos   <= pos;
      pos       <= pos + CW'(1);
    end
  end

  // request latch and result registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q    <= command;
      val_q    <= EW'(value);
      idx_q    <= index;
      status_q <= fqs_pkg::ST_OK;
      data_q   <= '0;
      found_q  <= '0;
    end
    if (ctl.exec) begin
      if ((cmd_q == fqs_pkg::CMD_ENQ) && full) status_q <= fqs_pkg::ST_OVER;
      if ((cmd_q == fqs_pkg::CMD_DEQ) && (cnt == '0)) status_q <= fqs_pkg::ST_UNDER;
      if ((cmd_q == fqs_pkg::CMD_READ) && !idx_ok) status_q <= fqs_pkg::ST_INDEX;
    end
    if (ctl.capture) data_q <= rd_data;
    if (ctl.search && match) found_q <= chk_pos + CW'(1);
    if (ctl.rd_back) fv <= (cnt != '0) ? rd_data : '0;
    if (ctl.finish)  bv <= (cnt != '0) ? rd_data : '0;
  end

  assign status         = status_q;
  assign data           = 32'(data_q);
  assign found_position = 5'(found_q);
  assign occupancy      = 5'(cnt);
  assign is_empty       = (cnt == '0);
  assign front_value    = 32'(fv);
  assign back_value     = 32'(bv);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= DEPTH_C)
    else $error("entry count above depth");

  a_pointer_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, fp} < DEPTH_W)
    else $error("front pointer outside ring");

  a_overflow_holds: assert property (@(posedge clk) disable iff (rst)
    (ctl.exec && (cmd_q == fqs_pkg::CMD_ENQ) && full) |=> $stable(cnt) && $stable(fp))
    else $error("enqueue on full queue changed it");

  a_dequeue_only_nonempty: assert property (@(posedge clk) disable iff (rst)
    (ctl.capture && (cmd_q == fqs_pkg::CMD_DEQ)) |-> (cnt != '0))
    else $error("dequeue capture on empty queue");

endmodule

@@ hdl/fifo_queue_with_search_core.sv @@
// ----------------------------------------------------------------------------
// fifo_queue_with_search_core
// Bounded queue in a ring store with enqueue, dequeue, indexed read, search,
// reverse and clear, reporting occupancy and front and back words per request.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Its result appears
// on the result ports for one cycle with done high, and must be taken then.
// Enqueue, reverse, clear and rejected requests step through execute, the
// front read, the back read and finish; dequeue and indexed read add a data
// capture step before the front read, and search reads entries until a match
// or the end of the queue. The store has a single read port that serves the
// entry reads, then the front word, then the back word, one per cycle.
module fifo_queue_with_search_core #(
  parameter int DEPTH         = 16,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic [2:0]  command,
  input  logic [31:0] value,
  input  logic [4:0]  index,
  output logic [1:0]  status,
  output logic [31:0] data,
  output logic [4:0]  found_position,
  output logic [4:0]  occupancy,
  output logic        is_empty,
  output logic [31:0] front_value,
  output logic [31:0] back_value
);

  fqs_pkg::dp_cmd_t  ctl;
  fqs_pkg::dp_stat_t stat;

  fqs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy),
    .done  (done)
  );

  fqs_dp #(
    .DEPTH         (DEPTH),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .stat           (stat),
    .command        (command),
    .value          (value),
    .index          (index),
    .status         (status),
    .data           (data),
    .found_position (found_position),
    .occupancy      (occupancy),
    .is_empty       (is_empty),
    .front_value    (front_value),
    .back_value     (back_value)
  );

endmodule
